// ===== rtl/core/rifb_pkg.sv =====
// Package for the rollback input frame buffer: operation codes, state
// enum and the slot mask and runway cap constants. No dependencies.
package rifb_pkg;

    typedef enum logic [3:0] {
        FN_CLEAR     = 4'd0,
        FN_STORE_LOC = 4'd1,
        FN_STORE_REM = 4'd2,
        FN_FETCH     = 4'd3,
        FN_PRED_MASK = 4'd4,
        FN_CONF_CNT  = 4'd5,
        FN_CONF_MASK = 4'd6,
        FN_SLOT_CONF = 4'd7,
        FN_RUNWAY    = 4'd8
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EXEC,
        ST_WALK,
        ST_WALK_CHK,
        ST_DONE
    } state_t;

    localparam logic [3:0] SLOT_MASK  = 4'hF;
    localparam int         RUNWAY_MAX = 127;

endpackage

// ===== rtl/core/rifb_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface rifb_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/rollback_input_frame_buffer_core.sv =====
// Rollback input frame buffer. One transfer in, one result out, one item at a
// time. Stores and queries pass through lookup, execute and done states;
// fetch and runway also walk back through the entry memory one frame at a
// time, each frame in a walk and a walk-check state, since the metadata
// memory read is registered. Fetch walks up to DEPTH frames and runway up
// to DEPTH-1. Clear skips the lookup and goes straight to done: entry valid
// bits sit in flip-flops. The next input is taken the cycle after the result
// transfer.
// Depends on rifb_pkg and rifb_if.
module rollback_input_frame_buffer_core #(
    parameter int DEPTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    rifb_if.sink   in_ch,
    rifb_if.source out_ch
);
    localparam int IW = $clog2(DEPTH);

    // metadata memory: tag, present, predicted; inputs memory: 4 words per row
    logic [39:0]  meta_mem [DEPTH];
    logic [127:0] word_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;

    logic [IW-1:0] rd_idx, wr_idx;
    logic          meta_we, word_we;
    logic [39:0]   meta_wd, meta_q;
    logic [127:0]  word_wd, word_q;

    always_ff @(posedge clk)
    begin
        if (meta_we) meta_mem[wr_idx] <= meta_wd;
        if (word_we) word_mem[wr_idx] <= word_wd;
        meta_q <= meta_mem[rd_idx];
        word_q <= word_mem[rd_idx];
    end

    rifb_pkg::state_t state_reg, state_next;
    logic [3:0]  func_reg;
    logic [7:0]  slot_reg, occ_reg, cnt_reg;
    logic [31:0] frame_reg, word_reg, newest_reg, newest_next;
    logic [31:0] cur_reg, cur_next;          // frame being looked at in a walk
    logic [IW:0] dist_reg, dist_next;        // walk step count
    logic [IW:0] lim_reg;
    logic [127:0] fill_reg, fill_next;       // fetch result words
    logic [3:0]  need_reg, need_next;        // slots still to predict
    logic [3:0]  pres_reg;                   // target entry metadata
    logic [6:0]  run_reg, run_next;
    logic [3:0]  fetch_pred_reg;

    // result register
    logic        acc_reg, acc_next, mis_reg, mis_next;
    logic [3:0]  pbits_reg, pbits_next;
    logic        ovalid_reg;

    logic [IW-1:0] rd_idx_q;
    wire         hit = valid_reg[rd_idx_q] && meta_q[39:8] == cur_reg;
    wire [3:0]   mpres = meta_q[7:4];
    wire [3:0]   mpred = meta_q[3:0];
    wire [3:0]   occ4  = occ_reg[3:0] & rifb_pkg::SLOT_MASK;
    wire         mconf = hit && occ4 != 4'd0 && ((occ4 & (~mpres | mpred)) == 4'd0);
    wire         slot_ok = slot_reg < 8'd4;

    assign in_ch.ready = state_reg == rifb_pkg::ST_IDLE && !ovalid_reg;
    wire in_xfer = in_ch.valid && in_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rifb_pkg::ST_IDLE:
                if (in_xfer)
                    state_next = (in_ch.data.func == rifb_pkg::FN_CLEAR) ?
                                 rifb_pkg::ST_DONE : rifb_pkg::ST_LOOK;
            rifb_pkg::ST_LOOK: state_next = rifb_pkg::ST_EXEC;
            rifb_pkg::ST_EXEC:
                if ((func_reg == rifb_pkg::FN_FETCH && need_next != 4'd0
                     && lim_reg != '0)
                    || (func_reg == rifb_pkg::FN_RUNWAY && !mconf
                        && dist_next < lim_reg))
                    state_next = rifb_pkg::ST_WALK;
                else
                    state_next = rifb_pkg::ST_DONE;
            rifb_pkg::ST_WALK: state_next = rifb_pkg::ST_WALK_CHK;
            rifb_pkg::ST_WALK_CHK:
                if ((func_reg == rifb_pkg::FN_FETCH && need_next != 4'd0
                     && dist_reg < lim_reg)
                    || (func_reg == rifb_pkg::FN_RUNWAY && !mconf
                        && dist_next < lim_reg))
                    state_next = rifb_pkg::ST_WALK;
                else
                    state_next = rifb_pkg::ST_DONE;
            rifb_pkg::ST_DONE: state_next = rifb_pkg::ST_IDLE;
            default: state_next = rifb_pkg::ST_IDLE;
        endcase
    end

    // datapath next values and memory controls
    always_comb
    begin
        rd_idx = cur_reg[IW-1:0];
        wr_idx = frame_reg[IW-1:0];
        meta_we = 1'b0;
        word_we = 1'b0;
        meta_wd = '0;
        word_wd = fill_reg;
        cur_next = cur_reg;
        dist_next = dist_reg;
        fill_next = fill_reg;
        need_next = need_reg;
        run_next = run_reg;
        acc_next = acc_reg;
        mis_next = mis_reg;
        pbits_next = pbits_reg;
        newest_next = newest_reg;
        if (state_reg == rifb_pkg::ST_IDLE)
            rd_idx = in_ch.data.frame[IW-1:0];
        case (state_reg)
            rifb_pkg::ST_IDLE:
                if (in_xfer)
                begin
                    cur_next = in_ch.data.frame;
                    acc_next = in_ch.data.func == rifb_pkg::FN_CLEAR;
                    mis_next = 1'b0;
                    pbits_next = 4'd0;
                    run_next = 7'd0;
                    fill_next = '0;
                    if (in_ch.data.func == rifb_pkg::FN_CLEAR)
                        newest_next = in_ch.data.frame;
                end
            rifb_pkg::ST_EXEC:
            begin
                acc_next = 1'b0; mis_next = 1'b0; pbits_next = 4'd0;
                run_next = 7'd0;
                dist_next = {{IW{1'b0}}, 1'b1};
                case (func_reg)
                    rifb_pkg::FN_STORE_LOC, rifb_pkg::FN_STORE_REM:
                        if (slot_ok)
                        begin
                            fill_next = hit ? word_q : '0;
                            if (func_reg == rifb_pkg::FN_STORE_REM && hit
                                && mpred[slot_reg[1:0]]
                                && word_q[slot_reg[1:0]*32 +: 32] != word_reg)
                                mis_next = 1'b1;
                            fill_next[slot_reg[1:0]*32 +: 32] = word_reg;
                            meta_we = 1'b1; word_we = 1'b1;
                            meta_wd = {frame_reg,
                                       (hit ? mpres : 4'd0) | (4'd1 << slot_reg[1:0]),
                                       (hit ? mpred : 4'd0) & ~(4'd1 << slot_reg[1:0])};
                            word_wd = fill_next;
                            acc_next = 1'b1;
                            if (frame_reg > newest_reg) newest_next = frame_reg;
                        end
                    rifb_pkg::FN_FETCH:
                    begin
                        fill_next = hit ? word_q : '0;
                        need_next = hit ? ~mpres : 4'hF;
                        for (int s = 0; s < 4; s++)
                            if (need_next[s]) fill_next[s*32 +: 32] = '0;
                        cur_next = frame_reg - 32'd1;
                        acc_next = 1'b1;
                        if (frame_reg > newest_reg) newest_next = frame_reg;
                    end
                    rifb_pkg::FN_PRED_MASK:
                        pbits_next = hit ? (occ4 & mpred) : occ4;
                    rifb_pkg::FN_CONF_CNT:
                        if (hit && cnt_reg >= 8'd1 && cnt_reg <= 8'd4)
                        begin
                            acc_next = 1'b1;
                            for (int s = 0; s < 4; s++)
                                if (s < cnt_reg && (!mpres[s] || mpred[s]))
                                    acc_next = 1'b0;
                        end
                    rifb_pkg::FN_CONF_MASK: acc_next = mconf;
                    rifb_pkg::FN_SLOT_CONF:
                        acc_next = slot_ok && hit && mpres[slot_reg[1:0]]
                                   && !mpred[slot_reg[1:0]];
                    rifb_pkg::FN_RUNWAY:
                    begin
                        if (!mconf) run_next = 7'd1;
                        cur_next = frame_reg - 32'd1;
                    end
                    default: ;
                endcase
            end
            rifb_pkg::ST_WALK_CHK:
            begin
                if (func_reg == rifb_pkg::FN_FETCH)
                begin
                    // the target row is claimed by this fetch: its old contents
                    // never count as an earlier frame
                    for (int s = 0; s < 4; s++)
                        if (need_reg[s] && hit && mpres[s]
                            && rd_idx_q != frame_reg[IW-1:0])
                        begin
                            fill_next[s*32 +: 32] = word_q[s*32 +: 32];
                            need_next[s] = 1'b0;
                        end
                end
                else if (!mconf && run_reg != 7'(rifb_pkg::RUNWAY_MAX))
                    run_next = run_reg + 7'd1;
                dist_next = dist_reg + 1'b1;
                cur_next = cur_reg - 32'd1;
            end
            rifb_pkg::ST_DONE:
                if (func_reg == rifb_pkg::FN_FETCH)
                begin
                    meta_we = 1'b1; word_we = 1'b1;
                    meta_wd = {frame_reg, pres_reg, fetch_pred_reg};
                    word_wd = fill_reg;
                end
                else
                    fill_next = '0;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rifb_pkg::ST_IDLE;
            valid_reg  <= '0;
            newest_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            newest_reg <= newest_next;
            if (in_xfer && in_ch.data.func == rifb_pkg::FN_CLEAR)
                valid_reg <= '0;
            else if (meta_we)
                valid_reg[wr_idx] <= 1'b1;
            if (state_reg == rifb_pkg::ST_DONE) ovalid_reg <= 1'b1;
            else if (out_ch.ready) ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_q <= rd_idx;
        cur_reg <= cur_next;
        dist_reg <= dist_next;
        fill_reg <= fill_next;
        need_reg <= need_next;
        run_reg <= run_next;
        acc_reg <= acc_next;
        mis_reg <= mis_next;
        pbits_reg <= pbits_next;
        if (in_xfer)
        begin
            func_reg  <= in_ch.data.func;
            slot_reg  <= in_ch.data.slot;
            frame_reg <= in_ch.data.frame;
            word_reg  <= in_ch.data.input_word;
            occ_reg   <= in_ch.data.occ_slots;
            cnt_reg   <= in_ch.data.check_count;
            lim_reg   <= (in_ch.data.frame < 32'(DEPTH)) ?
                         in_ch.data.frame[IW:0] : (IW+1)'(DEPTH);
        end
        if (state_reg == rifb_pkg::ST_EXEC)
        begin
            pres_reg <= hit ? mpres : 4'd0;
            fetch_pred_reg <= (hit ? mpred : 4'd0) | (hit ? ~mpres : 4'hF);
        end
        // runway uses frame+1 entries, fetch only frame earlier ones
        if (state_reg == rifb_pkg::ST_LOOK && func_reg == rifb_pkg::FN_RUNWAY)
            lim_reg <= (frame_reg < 32'(DEPTH)) ? (frame_reg[IW:0] + 1'b1)
                                                : (IW+1)'(DEPTH);
    end

    assign out_ch.valid = ovalid_reg;
    always_comb
    begin
        out_ch.data = '0;
        out_ch.data.accepted = acc_reg;
        out_ch.data.mismatch = mis_reg;
        if (func_reg == rifb_pkg::FN_FETCH)
        begin
            out_ch.data.player0_input = fill_reg[31:0];
            out_ch.data.player1_input = fill_reg[63:32];
            out_ch.data.player2_input = fill_reg[95:64];
            out_ch.data.player3_input = fill_reg[127:96];
        end
        out_ch.data.predicted_bits = pbits_reg;
        out_ch.data.runway = run_reg;
        out_ch.data.newest_frame_seen = newest_reg;
    end

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> state_reg == rifb_pkg::ST_IDLE) else $error("busy with result held");
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> !in_ch.ready) else $error("input taken while result pending");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rifb_pkg::ST_DONE |=> ovalid_reg) else $error("result lost");
endmodule

// ===== verif/rifb_tb_types.sv =====
// Transfer payload records for the frame buffer testbench: request and response
// layouts seen on in_ch and out_ch. Depends on nothing.
package rifb_tb_types;

    typedef struct packed {
        logic [3:0]  func;
        logic [7:0]  slot;
        logic [31:0] frame;
        logic [31:0] input_word;
        logic [7:0]  occ_slots;
        logic [7:0]  check_count;
    } frame_req_t;

    typedef struct packed {
        logic        accepted;
        logic        mismatch;
        logic [31:0] player0_input;
        logic [31:0] player1_input;
        logic [31:0] player2_input;
        logic [31:0] player3_input;
        logic [3:0]  predicted_bits;
        logic [6:0]  runway;
        logic [31:0] newest_frame_seen;
    } frame_rsp_t;

endpackage

// ===== verif/tb_rollback_input_frame_buffer_core.sv =====
// Testbench for rollback_input_frame_buffer_core: random and directed frame traffic
// checked against an in-bench timeline predictor. Depends on rifb_pkg, rifb_if,
// rifb_tb_types.
module tb_rollback_input_frame_buffer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING       = 64;
    localparam int CYCLE_CAP  = 800000;
    localparam int HOLD_SPAN  = 400;

    logic clk = 1'b0;
    logic rst_n;

    rifb_if #(.payload_t(rifb_tb_types::frame_req_t)) in_ch ();
    rifb_if #(.payload_t(rifb_tb_types::frame_rsp_t)) out_ch ();

    rollback_input_frame_buffer_core #(.DEPTH(RING)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // timeline predictor state
    logic        tl_valid [RING];
    logic [31:0] tl_tag   [RING];
    logic [31:0] tl_word  [RING][4];
    logic [3:0]  tl_here  [RING];
    logic [3:0]  tl_guess [RING];
    logic [31:0] tl_newest;

    rifb_tb_types::frame_req_t  pending_q[$];
    rifb_tb_types::frame_rsp_t  expected_q[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          idle_pct;
    int          stall_pct;
    int          sent_count = 0;
    int          checked_count = 0;
    int          mismatch_seen = 0;
    logic        hold_off;
    logic        press_go;
    logic        in_fire;

    always #5 clk = ~clk;

    function automatic int find_entry(input logic [31:0] fr);
        int i;
        i = fr % RING;
        if (tl_valid[i] && tl_tag[i] == fr)
            return i;
        return -1;
    endfunction

    function automatic int take_entry(input logic [31:0] fr);
        int i;
        i = fr % RING;
        if (!tl_valid[i] || tl_tag[i] != fr)
        begin
            tl_valid[i] = 1'b1;
            tl_tag[i]   = fr;
            tl_here[i]  = '0;
            tl_guess[i] = '0;
            for (int s = 0; s < 4; s++)
                tl_word[i][s] = '0;
        end
        return i;
    endfunction

    function automatic logic mask_confirmed(input logic [31:0] fr, input logic [7:0] occ);
        int       k;
        logic [3:0] m;
        k = find_entry(fr);
        m = occ[3:0] & rifb_pkg::SLOT_MASK;
        if (k < 0 || m == 4'd0)
            return 1'b0;
        for (int s = 0; s < 4; s++)
            if (m[s] && (!tl_here[k][s] || tl_guess[k][s]))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] prior_word(input int s, input logic [31:0] fr);
        int span;
        int k;
        span = (fr < RING) ? int'(fr) : RING;
        for (int d = 1; d <= span; d++)
        begin
            k = find_entry(fr - d);
            if (k >= 0 && tl_here[k][s])
                return tl_word[k][s];
        end
        return '0;
    endfunction

    function automatic rifb_tb_types::frame_rsp_t predict_result(
        input rifb_tb_types::frame_req_t r);
        rifb_tb_types::frame_rsp_t  o;
        int          i;
        int          k;
        int          lim;
        int          run;
        logic [31:0] fetched [4];
        o = '0;
        for (int s = 0; s < 4; s++)
            fetched[s] = '0;
        case (r.func)
            rifb_pkg::FN_CLEAR:
            begin
                for (int j = 0; j < RING; j++)
                    tl_valid[j] = 1'b0;
                tl_newest = r.frame;
                o.accepted = 1'b1;
            end
            rifb_pkg::FN_STORE_LOC, rifb_pkg::FN_STORE_REM:
            begin
                if (r.slot < 4)
                begin
                    i = take_entry(r.frame);
                    if (r.func == rifb_pkg::FN_STORE_REM && tl_guess[i][r.slot]
                        && tl_word[i][r.slot] != r.input_word)
                        o.mismatch = 1'b1;
                    tl_word[i][r.slot]  = r.input_word;
                    tl_here[i][r.slot]  = 1'b1;
                    tl_guess[i][r.slot] = 1'b0;
                    if (r.frame > tl_newest)
                        tl_newest = r.frame;
                    o.accepted = 1'b1;
                end
            end
            rifb_pkg::FN_FETCH:
            begin
                i = take_entry(r.frame);
                for (int s = 0; s < 4; s++)
                begin
                    if (!tl_here[i][s])
                    begin
                        tl_word[i][s]  = prior_word(s, r.frame);
                        tl_guess[i][s] = 1'b1;
                    end
                    fetched[s] = tl_word[i][s];
                end
                o.player0_input = fetched[0];
                o.player1_input = fetched[1];
                o.player2_input = fetched[2];
                o.player3_input = fetched[3];
                if (r.frame > tl_newest)
                    tl_newest = r.frame;
                o.accepted = 1'b1;
            end
            rifb_pkg::FN_PRED_MASK:
            begin
                k = find_entry(r.frame);
                if (k < 0)
                    o.predicted_bits = r.occ_slots[3:0];
                else
                    o.predicted_bits = r.occ_slots[3:0] & tl_guess[k];
            end
            rifb_pkg::FN_CONF_CNT:
            begin
                k = find_entry(r.frame);
                if (k >= 0 && r.check_count >= 1 && r.check_count <= 4)
                begin
                    o.accepted = 1'b1;
                    for (int s = 0; s < r.check_count; s++)
                        if (!tl_here[k][s] || tl_guess[k][s])
                            o.accepted = 1'b0;
                end
            end
            rifb_pkg::FN_CONF_MASK:
                o.accepted = mask_confirmed(r.frame, r.occ_slots);
            rifb_pkg::FN_SLOT_CONF:
            begin
                if (r.slot < 4)
                begin
                    k = find_entry(r.frame);
                    if (k >= 0 && tl_here[k][r.slot] && !tl_guess[k][r.slot])
                        o.accepted = 1'b1;
                end
            end
            rifb_pkg::FN_RUNWAY:
            begin
                lim = (r.frame < RING - 1) ? int'(r.frame) + 1 : RING;
                run = 0;
                for (int d = 0; d < lim; d++)
                begin
                    if (mask_confirmed(r.frame - d, r.occ_slots))
                        break;
                    run++;
                end
                o.runway = (run > rifb_pkg::RUNWAY_MAX) ? 7'(rifb_pkg::RUNWAY_MAX)
                                                        : 7'(run);
            end
            default:
                ;
        endcase
        o.newest_frame_seen = tl_newest;
        return o;
    endfunction

    task automatic report_error(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // predictor on input transfers, compare on output transfers
    always @(posedge clk)
    begin
        rifb_tb_types::frame_rsp_t w;
        rifb_tb_types::frame_rsp_t g;
        if (rst_n)
        begin
            in_fire <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
            begin
                expected_q.push_back(predict_result(in_ch.data));
                sent_count++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                g = out_ch.data;
                if (expected_q.size() == 0)
                    report_error("unexpected result", g.newest_frame_seen, 32'd0);
                else
                begin
                    w = expected_q.pop_front();
                    checked_count++;
                    if (g.mismatch)
                        mismatch_seen++;
                    if (g.accepted !== w.accepted)
                        report_error("accepted", 32'(g.accepted), 32'(w.accepted));
                    if (g.mismatch !== w.mismatch)
                        report_error("mismatch", 32'(g.mismatch), 32'(w.mismatch));
                    if (g.player0_input !== w.player0_input)
                        report_error("player0_input", g.player0_input, w.player0_input);
                    if (g.player1_input !== w.player1_input)
                        report_error("player1_input", g.player1_input, w.player1_input);
                    if (g.player2_input !== w.player2_input)
                        report_error("player2_input", g.player2_input, w.player2_input);
                    if (g.player3_input !== w.player3_input)
                        report_error("player3_input", g.player3_input, w.player3_input);
                    if (g.predicted_bits !== w.predicted_bits)
                        report_error("predicted_bits", 32'(g.predicted_bits),
                                     32'(w.predicted_bits));
                    if (g.runway !== w.runway)
                        report_error("runway", 32'(g.runway), 32'(w.runway));
                    if (g.newest_frame_seen !== w.newest_frame_seen)
                        report_error("newest_frame_seen", g.newest_frame_seen,
                                     w.newest_frame_seen);
                end
            end
        end
        else
        begin
            in_fire <= 1'b0;
            tl_newest = '0;
            for (int j = 0; j < RING; j++)
            begin
                tl_valid[j] = 1'b0;
                tl_tag[j]   = '0;
                tl_here[j]  = '0;
                tl_guess[j] = '0;
                for (int s = 0; s < 4; s++)
                    tl_word[j][s] = '0;
            end
        end
    end

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end
        else if (!in_ch.valid || in_fire)
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_q.pop_front();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // response back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        hold_off = 1'b0;
        wait (press_go);
        hold_off = 1'b1;
        repeat (HOLD_SPAN) @(posedge clk);
        hold_off = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_rollback_input_frame_buffer_core failed");
            $finish;
        end
    end

    function automatic rifb_tb_types::frame_req_t make_req(
        input logic [3:0] fn, input logic [7:0] sl,
        input logic [31:0] fr, input logic [31:0] wd,
        input logic [7:0] occ, input logic [7:0] cnt);
        rifb_tb_types::frame_req_t r;
        r.func        = fn;
        r.slot        = sl;
        r.frame       = fr;
        r.input_word  = wd;
        r.occ_slots   = occ;
        r.check_count = cnt;
        return r;
    endfunction

    task automatic drain_all();
        while (pending_q.size() != 0 || in_ch.valid || expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic queue_random(input int n, inout logic [31:0] head);
        logic [3:0]  fn;
        logic [7:0]  sl;
        logic [31:0] fr;
        logic [31:0] wd;
        int          pick;
        int          ix;
        for (int j = 0; j < n; j++)
        begin
            head = head + $urandom_range(0, 2);
            fr   = head - $urandom_range(0, 12);
            if ($urandom_range(99) < 3)
                fr = $urandom;
            sl   = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            wd   = ($urandom_range(3) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
            pick = $urandom_range(99);
            if (pick < 25)
                fn = rifb_pkg::FN_STORE_LOC;
            else if (pick < 45)
            begin
                fn = rifb_pkg::FN_STORE_REM;
                ix = fr % RING;
                // reuse the guessed word half the time to get both mismatch outcomes
                if ($urandom_range(1) == 0 && sl < 4)
                    wd = tl_word[ix][sl[1:0]];
            end
            else if (pick < 65)
                fn = rifb_pkg::FN_FETCH;
            else if (pick < 72)
                fn = rifb_pkg::FN_PRED_MASK;
            else if (pick < 79)
                fn = rifb_pkg::FN_CONF_CNT;
            else if (pick < 86)
                fn = rifb_pkg::FN_CONF_MASK;
            else if (pick < 92)
                fn = rifb_pkg::FN_SLOT_CONF;
            else if (pick < 98)
                fn = rifb_pkg::FN_RUNWAY;
            else if (pick < 99)
            begin
                fn = rifb_pkg::FN_CLEAR;
                fr = head - $urandom_range(0, 4);
            end
            else
                fn = 4'($urandom_range(9, 15));
            pending_q.push_back(make_req(fn, sl, fr, wd,
                                ($urandom_range(4) == 0) ? 8'($urandom) :
                                                           8'($urandom_range(1, 15)),
                                ($urandom_range(4) == 0) ? 8'($urandom) :
                                                           8'($urandom_range(1, 4))));
        end
    endtask

    initial
    begin
        logic [31:0] head;
        rst_n        = 1'b0;
        press_go     = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every operation, rejected slots and counts
        pending_q.push_back(make_req(rifb_pkg::FN_FETCH, 8'd0, 32'd0, 32'd0, 8'h0F, 8'd4));
        pending_q.push_back(make_req(rifb_pkg::FN_CLEAR, 8'd0, 32'd0, 32'd0, 8'd0, 8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_STORE_LOC, 8'd0, 32'd0, 32'hFFFF_FFFF,
                                     8'd0, 8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_STORE_LOC, 8'd3, 32'd2, 32'hA5A5_5A5A,
                                     8'd0, 8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_FETCH, 8'd0, 32'd3, 32'd0, 8'd0, 8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_STORE_REM, 8'd1, 32'd3, 32'h1234_5678,
                                     8'd0, 8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_STORE_REM, 8'd0, 32'd3, 32'hFFFF_FFFF,
                                     8'd0, 8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_STORE_LOC, 8'd255, 32'd3, 32'd1,
                                     8'd0, 8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_STORE_REM, 8'd4, 32'd3, 32'd1, 8'd0, 8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_PRED_MASK, 8'd0, 32'd3, 32'd0, 8'hFF, 8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_PRED_MASK, 8'd0, 32'd50, 32'd0, 8'hFA,
                                     8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_CONF_CNT, 8'd0, 32'd3, 32'd0, 8'd0, 8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_CONF_CNT, 8'd0, 32'd0, 32'd0, 8'd0, 8'd1));
        pending_q.push_back(make_req(rifb_pkg::FN_CONF_CNT, 8'd0, 32'd0, 32'd0, 8'd0,
                                     8'd255));
        pending_q.push_back(make_req(rifb_pkg::FN_CONF_MASK, 8'd0, 32'd0, 32'd0, 8'hF0,
                                     8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_CONF_MASK, 8'd0, 32'd0, 32'd0, 8'h01,
                                     8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_SLOT_CONF, 8'd4, 32'd0, 32'd0, 8'd0, 8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_SLOT_CONF, 8'd0, 32'd0, 32'd0, 8'd0, 8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_RUNWAY, 8'd0, 32'd3, 32'd0, 8'h0F, 8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_RUNWAY, 8'd0, 32'd200, 32'd0, 8'h0F, 8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_FETCH, 8'd0, 32'd70, 32'd0, 8'd0, 8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_FETCH, 8'd0, 32'hFFFF_FFFF, 32'd0,
                                     8'd0, 8'd0));
        pending_q.push_back(make_req(rifb_pkg::FN_RUNWAY, 8'd0, 32'hFFFF_FFFF, 32'd0,
                                     8'h0F, 8'd0));
        pending_q.push_back(make_req(4'd9, 8'd0, 32'd5, 32'd0, 8'd0, 8'd0));
        pending_q.push_back(make_req(4'd15, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
        drain_all();

        // no idling, with one long receiver hold-off to fill the block
        head = $urandom_range(0, 40);
        press_go = 1'b1;
        queue_random(160, head);
        drain_all();

        idle_pct = 64;
        head = 32'hFFFF_FFFF - $urandom_range(0, 300);
        queue_random(160, head);
        drain_all();

        idle_pct  = 0;
        stall_pct = 64;
        head = $urandom;
        queue_random(160, head);
        drain_all();

        idle_pct  = 33;
        stall_pct = 33;
        head = $urandom_range(0, 100);
        queue_random(160, head);
        drain_all();

        repeat (300) @(posedge clk);
        $display("covered %0d requests over all ops, idle/stall phases and one long hold-off",
                 sent_count);
        $display("%0d responses compared, %0d remote-store mismatches flagged",
                 checked_count, mismatch_seen);
        if (fail_count == 0)
            $display("tb_rollback_input_frame_buffer_core passed");
        else
            $display("tb_rollback_input_frame_buffer_core failed");
        $finish;
    end

endmodule
